@@ rtl/kld_pkg.sv @@
// ----------------------------------------------------------------------------
// kld_pkg
// Shared types and constants for the KL divergence accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package kld_pkg;

  localparam int unsigned IN_W  = 17;
  localparam int unsigned OUT_W = 48;

  // ln(2) in Q0.30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  typedef struct packed {
    logic [IN_W-1:0] p_value;
    logic [IN_W-1:0] q_value;
    logic            last_in_row;
    logic            skip;        // p or q is zero
  } kld_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_LN,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } kld_state_e;

endpackage
`default_nettype wire

@@ rtl/kld_in_if.sv @@
// ----------------------------------------------------------------------------
// kld_in_if
// Input channel: one (p, q) pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface kld_in_if;
  logic                      valid;
  logic                      ready;
  logic [kld_pkg::IN_W-1:0]  p_value;
  logic [kld_pkg::IN_W-1:0]  q_value;
  logic                      last_in_row;

  modport source (output valid, p_value, q_value, last_in_row, input ready);
  modport sink   (input valid, p_value, q_value, last_in_row, output ready);
endinterface
`default_nettype wire

@@ rtl/kld_out_if.sv @@
// ----------------------------------------------------------------------------
// kld_out_if
// Output channel: one row result per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface kld_out_if;
  logic                      valid;
  logic                      ready;
  logic [kld_pkg::OUT_W-1:0] divergence;
  logic                      overflow;

  modport source (output valid, divergence, overflow, input ready);
  modport sink   (input valid, divergence, overflow, output ready);
endinterface
`default_nettype wire

@@ rtl/kld_front.sv @@
// ----------------------------------------------------------------------------
// kld_front
// Accepts pairs, flags zero samples and queues them (two entries).
// ----------------------------------------------------------------------------
`default_nettype none
module kld_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  kld_in_if.sink             in_i,
  output kld_pkg::kld_item_t item_o,
  output logic               item_valid_o,
  input  wire logic          item_ready_i
);

  kld_pkg::kld_item_t slot_q [2];
  logic               rd_ptr_q, wr_ptr_q;
  logic [1:0]         count_q;
  logic               push, pop;

  assign in_i.ready   = (count_q != 2'd2);
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q].p_value     <= in_i.p_value;
      slot_q[wr_ptr_q].q_value     <= in_i.q_value;
      slot_q[wr_ptr_q].last_in_row <= in_i.last_in_row;
      slot_q[wr_ptr_q].skip        <= (in_i.p_value == '0) || (in_i.q_value == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !pop) |=> count_q == 2'd2) else $error("full queue lost an entry");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |-> (rd_ptr_q == wr_ptr_q)) else $error("empty queue pointers differ");
`endif

endmodule
`default_nettype wire

@@ rtl/kld_back.sv @@
// ----------------------------------------------------------------------------
// kld_back
// Log2 by repeated squaring, ln scaling, p weighting, saturating accumulate.
// ----------------------------------------------------------------------------
`default_nettype none
module kld_back #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ACC_WIDTH = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire kld_pkg::kld_item_t item_i,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  kld_out_if.source               out_o
);

  localparam int unsigned LW = 5 + FRAC_BITS;      // log2 value width
  localparam int unsigned CW = $clog2(FRAC_BITS);
  localparam int unsigned RW = LW;                 // |ln ratio|
  localparam int unsigned TW = RW + 2;             // |term|
  localparam int unsigned IW = kld_pkg::IN_W;
  localparam int unsigned OW = kld_pkg::OUT_W;

  kld_pkg::kld_state_e state_q, state_d;
  kld_pkg::kld_item_t  item_q;

  logic                 sel_q;
  logic [CW-1:0]        cnt_q;
  logic [30:0]          m_q;
  logic [4:0]           e_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [LW-1:0]        lp_q;
  logic                 neg_q;
  logic [LW-1:0]        dmag_q;
  logic [RW-1:0]        rmag_q;
  logic [TW-1:0]        tmag_q;
  logic [ACC_WIDTH-1:0] sum_q;
  logic                 sat_q;
  logic                 out_valid_q;
  logic [OW-1:0]        div_q;
  logic                 ovf_q;

  // squaring step
  logic [61:0]          sq;
  logic [31:0]          sq_hi;
  logic                 fbit;
  logic [30:0]          m_d;
  logic [FRAC_BITS-1:0] frac_d;
  logic                 log_done;

  assign sq     = 62'(m_q) * 62'(m_q);
  assign sq_hi  = sq[61:30];
  assign fbit   = sq_hi[31];
  assign m_d    = fbit ? sq_hi[31:1] : sq_hi[30:0];
  assign frac_d = {frac_q[FRAC_BITS-2:0], fbit};
  assign log_done = (cnt_q == CW'(FRAC_BITS - 1));

  // normalization of the next operand
  logic [IW-1:0] x_sel;
  logic [4:0]    x_e;
  logic [30:0]   x_m;

  always_comb begin
    // p is loaded while idle, q once the p log is done
    x_sel = (state_q == kld_pkg::ST_LOG) ? item_q.q_value : item_i.p_value;
    x_e = '0;
    for (int i = 0; i < IW; i++) begin
      if (x_sel[i]) x_e = 5'(i);
    end
    x_m = 31'({14'b0, x_sel}) << (5'd30 - x_e);
  end

  // difference of the logs
  logic [LW-1:0] lq;
  logic [LW:0]   diff;
  assign lq   = {e_q, frac_d};
  assign diff = {1'b0, lp_q} - {1'b0, lq};

  // ln scaling and weighting
  logic [LW+29:0] ln_prod;
  logic [RW+IW:0] t_prod;
  assign ln_prod = (LW+30)'(dmag_q) * (LW+30)'(kld_pkg::LN2_Q30)
                 + ((LW+30)'(1) << 29);
  assign t_prod  = (RW+IW+1)'(rmag_q) * (RW+IW+1)'(item_q.p_value)
                 + ((RW+IW+1)'(1) << 15);

  // saturating accumulate
  logic signed [ACC_WIDTH:0]   term_ext, acc_ext, hi_ext, lo_ext;
  logic [ACC_WIDTH-1:0]        sum_next;
  logic                        sat_hit;

  always_comb begin
    term_ext = neg_q ? -$signed((ACC_WIDTH+1)'(tmag_q)) : $signed((ACC_WIDTH+1)'(tmag_q));
    acc_ext  = $signed({sum_q[ACC_WIDTH-1], sum_q}) + term_ext;
    hi_ext   = $signed({2'b00, {(ACC_WIDTH-1){1'b1}}});
    lo_ext   = $signed({2'b11, {(ACC_WIDTH-1){1'b0}}});
    sat_hit  = 1'b0;
    sum_next = acc_ext[ACC_WIDTH-1:0];
    if (acc_ext > hi_ext) begin
      sum_next = hi_ext[ACC_WIDTH-1:0];
      sat_hit  = 1'b1;
    end else if (acc_ext < lo_ext) begin
      sum_next = lo_ext[ACC_WIDTH-1:0];
      sat_hit  = 1'b1;
    end
  end

  logic out_free;
  assign out_free     = !out_valid_q || out_o.ready;
  assign item_ready_o = (state_q == kld_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      kld_pkg::ST_IDLE: if (item_valid_i) begin
        state_d = item_i.skip ? kld_pkg::ST_ACC : kld_pkg::ST_LOG;
      end
      kld_pkg::ST_LOG:  if (log_done && sel_q) state_d = kld_pkg::ST_LN;
      kld_pkg::ST_LN:   state_d = kld_pkg::ST_MUL;
      kld_pkg::ST_MUL:  state_d = kld_pkg::ST_ACC;
      kld_pkg::ST_ACC:  state_d = item_q.last_in_row ? kld_pkg::ST_OUT : kld_pkg::ST_IDLE;
      kld_pkg::ST_OUT:  if (out_free) state_d = kld_pkg::ST_IDLE;
      default:          state_d = kld_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kld_pkg::ST_IDLE;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == kld_pkg::ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready)                       out_valid_q <= 1'b0;
      if (state_q == kld_pkg::ST_ACC) begin
        sum_q <= sum_next;
        if (sat_hit) sat_q <= 1'b1;
      end
      if (state_q == kld_pkg::ST_OUT && out_free) begin
        sum_q       <= '0;
        sat_q       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      kld_pkg::ST_IDLE: begin
        item_q <= item_i;
        sel_q  <= 1'b0;
        cnt_q  <= '0;
        frac_q <= '0;
        e_q    <= x_e;
        m_q    <= x_m;
        neg_q  <= 1'b0;
        tmag_q <= '0;
      end
      kld_pkg::ST_LOG: begin
        if (!log_done) begin
          cnt_q  <= cnt_q + CW'(1);
          m_q    <= m_d;
          frac_q <= frac_d;
        end else begin
          cnt_q  <= '0;
          frac_q <= '0;
          if (!sel_q) begin
            // p done, start q
            lp_q  <= {e_q, frac_d};
            sel_q <= 1'b1;
            e_q   <= x_e;
            m_q   <= x_m;
          end else begin
            neg_q  <= diff[LW];
            dmag_q <= diff[LW] ? LW'(-diff) : diff[LW-1:0];
          end
        end
      end
      kld_pkg::ST_LN:  rmag_q <= ln_prod[RW+29:30];
      kld_pkg::ST_MUL: tmag_q <= t_prod[TW+15:16];
      kld_pkg::ST_OUT: if (out_free) begin
        div_q <= OW'({{OW{sum_q[ACC_WIDTH-1]}}, sum_q});
        ovf_q <= sat_q;
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.divergence = div_q;
  assign out_o.overflow   = ovf_q;

`ifndef SYNTHESIS
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sat_q) |-> (sum_q == {1'b0, {(ACC_WIDTH-1){1'b1}}}
                   || sum_q == {1'b1, {(ACC_WIDTH-1){1'b0}}}))
    else $error("overflow set without saturated sum");
  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kld_pkg::ST_LOG) |-> m_q[30]) else $error("mantissa not normalized");
  a_out_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kld_pkg::ST_OUT && out_free) |=> (sum_q == '0 && !sat_q && out_valid_q))
    else $error("row end did not clear the sum");
`endif

endmodule
`default_nettype wire

@@ rtl/kl_divergence_accumulator.sv @@
// Sequence: a nonzero pair runs the p log, then the q log, then the ln, multiply and
//   accumulate states; a pair with a zero sample goes straight to accumulate.
// One squarer serves both logs; the block takes no new pair until the last one is
//   through, and a row's last pair adds the output state, which waits out any output
//   stall; a two-entry queue buffers input.
// Reset: asynchronous, active low; clears the sum, overflow flag and queue.
// ----------------------------------------------------------------------------
// kl_divergence_accumulator
// Row-wise sum of p*ln(p/q) with saturation and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none
module kl_divergence_accumulator #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ACC_WIDTH = 48
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kld_in_if.sink    in_i,
  kld_out_if.source out_o
);

  kld_pkg::kld_item_t item;
  logic               item_valid;
  logic               item_ready;

  kld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  kld_back #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire
